// ----- rtl/core/mlf_pkg.sv -----
package mlf_pkg;

   // Field widths of a frame header and of a result
   localparam int MAC_W      = 48;
   localparam int PORT_W     = 4;
   localparam int ACT_W      = 2;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;

   // Result action codes
   localparam logic [ACT_W-1:0] ACT_UNICAST = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BCAST   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DISCARD = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             load;    // capture the frame header
      logic             cmp;     // compare source and destination against the table
      logic             learn;   // update the table with the source MAC
      logic             emit;    // load the output register
      logic [ACT_W-1:0] act;     // action of the result being loaded
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic dst_hit;     // destination found after learning
      logic all_ones;    // destination is the broadcast address
      logic bcast_pend;  // broadcast copies left to send
      logic bcast_last;  // the next broadcast copy is the final one
      logic out_free;    // output register can take a result this cycle
   } sts_type;

endpackage

// ----- rtl/core/mlf_datapath.sv -----
module mlf_datapath #(
   parameter int TABLE_DEPTH = 16,
   parameter int PORT_COUNT  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // dst_mac [47:0], src_mac [95:48], src_port [99:96], zero [103:100]
   input  logic [mlf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  mlf_pkg::cmd_type                cmd,
   output mlf_pkg::sts_type                sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_port [3:0], learned_new [4], table_full [5], zero [7:6]
   output logic [mlf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // action [1:0]
   output logic [mlf_pkg::ACT_W-1:0]       rsp_tuser,
   output logic                            rsp_tlast
);
   import mlf_pkg::*;

   localparam int PCNT_W = 9;

   // Captured frame header
   logic [MAC_W-1:0]  dst_mac_ff;
   logic [MAC_W-1:0]  src_mac_ff;
   logic [PORT_W-1:0] src_port_ff;
   logic              src_ok_ff;

   // Forwarding table
   logic [MAC_W-1:0]       entry_mac_ff  [TABLE_DEPTH];
   logic [PORT_W-1:0]      entry_port_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] entry_valid_ff;

   // Compare results and per-frame working vectors
   logic [TABLE_DEPTH-1:0] src_hit_in, src_hit_ff;
   logic [TABLE_DEPTH-1:0] dst_hit_in, dst_hit_ff;
   logic                   dst_eq_src_ff;
   logic [TABLE_DEPTH-1:0] dst_vec_ff;
   logic [TABLE_DEPTH-1:0] mask_ff;
   logic                   learned_ff;
   logic                   full_ff;

   // Output register
   logic                   rsp_tvalid_ff;
   logic [PORT_W-1:0]      rsp_port_ff, rsp_port_in;
   logic [ACT_W-1:0]       rsp_act_ff;
   logic                   rsp_learned_ff;
   logic                   rsp_full_ff;
   logic                   rsp_last_ff;

   logic [TABLE_DEPTH-1:0] free_vec, free_low, wr_vec;
   logic [TABLE_DEPTH-1:0] bc_low, bc_rest;
   logic                   src_known, any_free, do_write;
   logic [PORT_W-1:0]      uni_port, bc_port;

   // Capture the header and check the arrival port range
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dst_mac_ff  <= req_tdata[MAC_W-1:0];
         src_mac_ff  <= req_tdata[2*MAC_W-1:MAC_W];
         src_port_ff <= req_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
         src_ok_ff   <= {{(PCNT_W-PORT_W){1'b0}}, req_tdata[2*MAC_W+PORT_W-1:2*MAC_W]}
                        < PCNT_W'(PORT_COUNT);
      end
   end

   // Compare every entry against source and destination
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         src_hit_in[i] = entry_valid_ff[i] && (entry_mac_ff[i] == src_mac_ff);
         dst_hit_in[i] = entry_valid_ff[i] && (entry_mac_ff[i] == dst_mac_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp) begin
         src_hit_ff    <= src_hit_in;
         dst_hit_ff    <= dst_hit_in;
         dst_eq_src_ff <= dst_mac_ff == src_mac_ff;
      end
   end

   // Pick the entry to write: the known one, else the lowest free one
   assign free_vec  = ~entry_valid_ff;
   assign free_low  = free_vec & (~free_vec + 1'b1);
   assign src_known = |src_hit_ff;
   assign any_free  = |free_vec;
   assign wr_vec    = src_known ? src_hit_ff : free_low;
   assign do_write  = src_ok_ff && (src_known || any_free);

   // Learn the source MAC
   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cmd.learn && do_write && wr_vec[i]) begin
            entry_mac_ff[i]  <= src_mac_ff;
            entry_port_ff[i] <= src_port_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (cmd.learn && do_write) begin
         entry_valid_ff <= entry_valid_ff | wr_vec;
      end
   end

   // Settle the destination hit and the broadcast recipients after learning
   always_ff @(posedge clock) begin
      if (cmd.learn) begin
         dst_vec_ff <= dst_hit_ff | ((dst_eq_src_ff && do_write) ? wr_vec : '0);
         learned_ff <= src_ok_ff && !src_known && any_free;
         full_ff    <= src_ok_ff && !src_known && !any_free;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.learn) begin
         mask_ff <= entry_valid_ff & ~src_hit_ff;
      end else if (cmd.emit && (cmd.act == ACT_BCAST)) begin
         mask_ff <= bc_rest;
      end
   end

   // Select ports from one-hot vectors
   assign bc_low  = mask_ff & (~mask_ff + 1'b1);
   assign bc_rest = mask_ff & ~bc_low;

   always_comb begin
      uni_port = '0;
      bc_port  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         uni_port = uni_port | (dst_vec_ff[i] ? entry_port_ff[i] : '0);
         bc_port  = bc_port  | (bc_low[i]     ? entry_port_ff[i] : '0);
      end
   end

   always_comb begin
      case (cmd.act)
         ACT_UNICAST: rsp_port_in = uni_port;
         ACT_BCAST:   rsp_port_in = bc_port;
         default:     rsp_port_in = '0;
      endcase
   end

   // Hold a result until its transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_port_ff    <= rsp_port_in;
         rsp_act_ff     <= cmd.act;
         rsp_learned_ff <= learned_ff;
         rsp_full_ff    <= full_ff;
         rsp_last_ff    <= (cmd.act != ACT_BCAST) || (bc_rest == '0);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_full_ff, rsp_learned_ff, rsp_port_ff};
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sts.dst_hit    = |dst_vec_ff;
   assign sts.all_ones   = &dst_mac_ff;
   assign sts.bcast_pend = |mask_ff;
   assign sts.bcast_last = bc_rest == '0;
   assign sts.out_free   = !rsp_tvalid_ff || rsp_tready;

`ifndef SYNTHESIS
   // A MAC lives in at most one entry
   a_src_unique: assert property (@(posedge clock) disable iff (reset)
      cmd.learn |-> $onehot0(src_hit_ff))
      else $error("source MAC matches several entries");

   a_dst_unique: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && (cmd.act == ACT_UNICAST) |-> $onehot(dst_vec_ff))
      else $error("unicast result without a single destination entry");

   a_bcast_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && (cmd.act == ACT_BCAST) |-> (mask_ff != '0))
      else $error("broadcast copy with no recipient left");

   a_valid_keep: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((entry_valid_ff & $past(entry_valid_ff)) == $past(entry_valid_ff)))
      else $error("table entry lost its valid bit");
`endif

endmodule

// ----- rtl/core/mlf_ctrl.sv -----
module mlf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  mlf_pkg::sts_type sts,
   output mlf_pkg::cmd_type cmd
);
   import mlf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CMP    = 5'b00010,
      ST_LEARN  = 5'b00100,
      ST_RESULT = 5'b01000,
      ST_BCAST  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

   // Sequence one frame: capture, compare, learn, then send results
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.act   = ACT_UNICAST;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_LEARN;
         end
         ST_LEARN: begin
            cmd.learn = 1'b1;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
               if (sts.dst_hit) begin
                  cmd.act = ACT_UNICAST;
               end else if (!sts.all_ones) begin
                  cmd.act = ACT_DISCARD;
               end else if (!sts.bcast_pend) begin
                  cmd.act = ACT_NONE;
               end else begin
                  cmd.act = ACT_BCAST;
                  if (!sts.bcast_last) begin
                     state_in = ST_BCAST;
                  end
               end
            end
         end
         ST_BCAST: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.act  = ACT_BCAST;
               if (sts.bcast_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/mac_learning_forwarder_unit.sv -----
// The first result is loaded in the result state, which follows capture,
// compare and learn and waits while the output register is full. A new header
// is taken only in idle, after the last result of a frame; a broadcast to n
// entries sends one copy per cycle while the single output register is free.
// Reset: synchronous, active high; clears all table valid bits at once and
// returns the sequencer to idle. No clearing pass is needed.
module mac_learning_forwarder_unit #(
   parameter int TABLE_DEPTH = 16,
   parameter int PORT_COUNT  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // dst_mac [47:0], src_mac [95:48], src_port [99:96], zero [103:100]
   input  logic [mlf_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_port [3:0], learned_new [4], table_full [5], zero [7:6]
   output logic [mlf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // action [1:0]
   output logic [mlf_pkg::ACT_W-1:0]       rsp_tuser,
   output logic                            rsp_tlast
);
   import mlf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   mlf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Table, compare logic and output register
   mlf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PORT_COUNT  (PORT_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
